// ===== rtl/bsp_pkg.sv =====
`timescale 1ns / 1ps
package bsp_pkg;

    // Number formats.
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 12;
    localparam int COORD_W    = 32;
    localparam int ITER_W     = 12;
    localparam int COLOR_W    = 8;
    localparam int T_BITS     = 16;

    // Magnitude of x and y after a step that passed the escape test stays below
    // 4 + |c|, so it needs a few integer bits over the fraction, and at least
    // room for the 32-bit color operands that share the multiplier.
    localparam int MAG_W  = ((FRAC_BITS + 3 > COORD_W - 1) ? FRAC_BITS + 3 : COORD_W - 1) + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SQ_W   = PROD_W - FRAC_BITS;

    // Color polynomial scale factors: 9*255, 15*255 and 2*8.5*255.
    localparam int C_RED   = 2295;
    localparam int C_GREEN = 3825;
    localparam int C_BLUE  = 4335;

    // Pixel sequencer states.
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SQX  = 9'b000000010,
        ST_SQY  = 9'b000000100,
        ST_MXY  = 9'b000001000,
        ST_UPD  = 9'b000010000,
        ST_DIV  = 9'b000100000,
        ST_CMUL = 9'b001000000,
        ST_CWR  = 9'b010000000,
        ST_DONE = 9'b100000000
    } bsp_state_t;

    // Color micro-operations, run in this order on the shared multiplier.
    typedef enum logic [3:0] {
        COP_TT   = 4'd0,
        COP_T2T  = 4'd1,
        COP_UU   = 4'd2,
        COP_U2U  = 4'd3,
        COP_UT3  = 4'd4,
        COP_RED  = 4'd5,
        COP_U2T2 = 4'd6,
        COP_GRN  = 4'd7,
        COP_U3T  = 4'd8,
        COP_BLU  = 4'd9
    } bsp_cop_t;

endpackage

// ===== rtl/bsp_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: quot = floor(dividend * 2^T_BITS / divisor).
// The dividend must be below the divisor.
module bsp_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [bsp_pkg::COUNT_BITS-1:0]   dividend,
    input  logic [bsp_pkg::COUNT_BITS-1:0]   divisor,
    output logic                             done,
    output logic [bsp_pkg::T_BITS-1:0]       quot
);

    localparam int CNT_W = $clog2(bsp_pkg::T_BITS + 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [bsp_pkg::COUNT_BITS-1:0] rem_reg, rem_next;
    logic [bsp_pkg::T_BITS-1:0]     quot_reg, quot_next;
    logic [bsp_pkg::COUNT_BITS:0]   shifted;
    logic [bsp_pkg::COUNT_BITS:0]   trial;
    logic                           fits;

    // One shift-and-subtract step per cycle.
    always_comb begin
        shifted   = {rem_reg, 1'b0};
        trial     = shifted - {1'b0, divisor};
        fits      = (shifted >= {1'b0, divisor});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend;
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = fits ? trial[bsp_pkg::COUNT_BITS-1:0]
                             : shifted[bsp_pkg::COUNT_BITS-1:0];
            quot_next = {quot_reg[bsp_pkg::T_BITS-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(bsp_pkg::T_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/burning_ship_pixel.sv =====
`timescale 1ns / 1ps
// Channel  Ports                                          Direction  Handshake
// input    s_c_real, s_c_imag, s_iter_limit               in         s_valid / s_ready
// result   m_iterations, m_inside_set, m_red/green/blue   out        m_valid / m_ready
//
// A recurrence step runs through ST_SQX, ST_SQY and ST_MXY, three products on the one shared multiplier, then ST_UPD.
// A point that escapes goes from its last step through the wait on the 16-step divider, the color products
// (each a ST_CMUL and a ST_CWR state), the result state and the idle state; a point that reaches the limit L
// goes from its last step straight to the result state.
// s_ready is high only while the sequencer is idle; one point is worked on at a time.
// The result word sits in an output register, so the next point is taken while it waits.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
module burning_ship_pixel (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [bsp_pkg::COORD_W-1:0] s_c_real,
    input  logic signed [bsp_pkg::COORD_W-1:0] s_c_imag,
    input  logic [bsp_pkg::ITER_W-1:0]    s_iter_limit,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bsp_pkg::ITER_W-1:0]    m_iterations,
    output logic                          m_inside_set,
    output logic [bsp_pkg::COLOR_W-1:0]   m_red,
    output logic [bsp_pkg::COLOR_W-1:0]   m_green,
    output logic [bsp_pkg::COLOR_W-1:0]   m_blue
);

    localparam int MAG_W  = bsp_pkg::MAG_W;
    localparam int PROD_W = bsp_pkg::PROD_W;
    localparam int SQ_W   = bsp_pkg::SQ_W;
    localparam int CNT_W  = bsp_pkg::COUNT_BITS;
    localparam int T_W    = bsp_pkg::T_BITS;
    localparam int CW     = bsp_pkg::COLOR_W;
    localparam int CRD_W  = bsp_pkg::COORD_W;
    localparam int EXT_W  = SQ_W + 2;

    localparam logic [SQ_W:0]  BOUND   = (SQ_W + 1)'(1) << (bsp_pkg::FRAC_BITS + 2);
    localparam logic [T_W:0]   T_ONE   = (T_W + 1)'(1) << T_W;

    bsp_pkg::bsp_state_t st_reg, st_next;
    bsp_pkg::bsp_cop_t   cop_reg, cop_next;
    logic                m_valid_reg, m_valid_next;

    logic signed [CRD_W-1:0] cr_reg, ci_reg;
    logic [CNT_W-1:0]        limit_reg, count_reg;
    logic [MAG_W-1:0]        ax_reg, ay_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [SQ_W-1:0]         sx_reg, sy_reg;
    logic                    esc_reg, inside_reg;
    logic [T_W-1:0]          t_reg, t2_reg, t3_reg;
    logic [T_W:0]            u_reg, u2_reg, u3_reg;
    logic [2*T_W-1:0]        tmp_reg;
    logic [CW-1:0]           red_reg, green_reg, blue_reg;
    logic [bsp_pkg::ITER_W-1:0] m_iterations_reg;
    logic                    m_inside_set_reg;
    logic [CW-1:0]           m_red_reg, m_green_reg, m_blue_reg;

    logic                    accept, out_free;
    logic [CNT_W-1:0]        limit_in, count_inc;
    logic [MAG_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic [SQ_W-1:0]         sq_cur;
    logic                    esc_now;
    logic signed [EXT_W-1:0] cr_ext, ci_ext, x_sum, y_sum, x_abs, y_abs;
    logic                    div_start, div_done;
    logic [T_W-1:0]          div_quot;

    assign s_ready   = (st_reg == bsp_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign limit_in  = CNT_W'(s_iter_limit);
    assign count_inc = count_reg + 1'b1;

    // Shared multiplier operand select.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (st_reg)
            bsp_pkg::ST_SQX: begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            bsp_pkg::ST_SQY: begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            bsp_pkg::ST_MXY: begin
                mul_a = ax_reg;
                mul_b = ay_reg;
            end
            bsp_pkg::ST_CMUL: begin
                case (cop_reg)
                    bsp_pkg::COP_TT: begin
                        mul_a = MAG_W'(t_reg);
                        mul_b = MAG_W'(t_reg);
                    end
                    bsp_pkg::COP_T2T: begin
                        mul_a = MAG_W'(t2_reg);
                        mul_b = MAG_W'(t_reg);
                    end
                    bsp_pkg::COP_UU: begin
                        mul_a = MAG_W'(u_reg);
                        mul_b = MAG_W'(u_reg);
                    end
                    bsp_pkg::COP_U2U: begin
                        mul_a = MAG_W'(u2_reg);
                        mul_b = MAG_W'(u_reg);
                    end
                    bsp_pkg::COP_UT3: begin
                        mul_a = MAG_W'(u_reg);
                        mul_b = MAG_W'(t3_reg);
                    end
                    bsp_pkg::COP_RED: begin
                        mul_a = MAG_W'(bsp_pkg::C_RED);
                        mul_b = MAG_W'(tmp_reg);
                    end
                    bsp_pkg::COP_U2T2: begin
                        mul_a = MAG_W'(u2_reg);
                        mul_b = MAG_W'(t2_reg);
                    end
                    bsp_pkg::COP_GRN: begin
                        mul_a = MAG_W'(bsp_pkg::C_GREEN);
                        mul_b = MAG_W'(tmp_reg);
                    end
                    bsp_pkg::COP_U3T: begin
                        mul_a = MAG_W'(u3_reg);
                        mul_b = MAG_W'(t_reg);
                    end
                    bsp_pkg::COP_BLU: begin
                        mul_a = MAG_W'(bsp_pkg::C_BLUE);
                        mul_b = MAG_W'(tmp_reg);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign sq_cur = prod_reg[bsp_pkg::FRAC_BITS +: SQ_W];

    // Escape test on the two squares, and the next x and y magnitudes.
    assign esc_now = ({1'b0, sx_reg} + {1'b0, sq_cur}) > BOUND;
    assign cr_ext  = {{(EXT_W - CRD_W){cr_reg[CRD_W-1]}}, cr_reg};
    assign ci_ext  = {{(EXT_W - CRD_W){ci_reg[CRD_W-1]}}, ci_reg};
    assign x_sum   = $signed({2'b00, sx_reg}) - $signed({2'b00, sy_reg}) + cr_ext;
    assign y_sum   = $signed({1'b0, sq_cur, 1'b0}) + ci_ext;
    assign x_abs   = x_sum[EXT_W-1] ? -x_sum : x_sum;
    assign y_abs   = y_sum[EXT_W-1] ? -y_sum : y_sum;

    // The divider starts in the update state once the registered escape flag is set.
    assign div_start = (st_reg == bsp_pkg::ST_UPD) && esc_reg;

    bsp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (count_reg),
        .divisor  (limit_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    // Sequencer next state.
    always_comb begin
        st_next      = st_reg;
        cop_next     = cop_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        unique case (st_reg)
            bsp_pkg::ST_IDLE: begin
                if (accept) begin
                    st_next = (limit_in == '0) ? bsp_pkg::ST_DONE : bsp_pkg::ST_SQX;
                end
            end
            bsp_pkg::ST_SQX: st_next = bsp_pkg::ST_SQY;
            bsp_pkg::ST_SQY: st_next = bsp_pkg::ST_MXY;
            bsp_pkg::ST_MXY: st_next = bsp_pkg::ST_UPD;
            bsp_pkg::ST_UPD: begin
                if (esc_reg) begin
                    st_next = bsp_pkg::ST_DIV;
                end else if (count_inc == limit_reg) begin
                    st_next = bsp_pkg::ST_DONE;
                end else begin
                    st_next = bsp_pkg::ST_SQX;
                end
            end
            bsp_pkg::ST_DIV: begin
                if (div_done) begin
                    st_next  = bsp_pkg::ST_CMUL;
                    cop_next = bsp_pkg::COP_TT;
                end
            end
            bsp_pkg::ST_CMUL: st_next = bsp_pkg::ST_CWR;
            bsp_pkg::ST_CWR: begin
                if (cop_reg == bsp_pkg::COP_BLU) begin
                    st_next = bsp_pkg::ST_DONE;
                end else begin
                    st_next  = bsp_pkg::ST_CMUL;
                    cop_next = bsp_pkg::bsp_cop_t'(cop_reg + 1'b1);
                end
            end
            bsp_pkg::ST_DONE: begin
                if (out_free) begin
                    st_next      = bsp_pkg::ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: st_next = bsp_pkg::ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= bsp_pkg::ST_IDLE;
            cop_reg     <= bsp_pkg::COP_TT;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            cop_reg     <= cop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (st_reg)
            bsp_pkg::ST_IDLE: begin
                if (accept) begin
                    cr_reg     <= s_c_real;
                    ci_reg     <= s_c_imag;
                    limit_reg  <= limit_in;
                    count_reg  <= '0;
                    ax_reg     <= '0;
                    ay_reg     <= '0;
                    inside_reg <= (limit_in == '0);
                    red_reg    <= '0;
                    green_reg  <= '0;
                    blue_reg   <= '0;
                end
            end
            bsp_pkg::ST_SQX: prod_reg <= mul_p;
            bsp_pkg::ST_SQY: begin
                sx_reg   <= sq_cur;
                prod_reg <= mul_p;
            end
            bsp_pkg::ST_MXY: begin
                sy_reg   <= sq_cur;
                esc_reg  <= esc_now;
                prod_reg <= mul_p;
            end
            bsp_pkg::ST_UPD: begin
                if (!esc_reg) begin
                    ax_reg     <= x_abs[MAG_W-1:0];
                    ay_reg     <= y_abs[MAG_W-1:0];
                    count_reg  <= count_inc;
                    inside_reg <= (count_inc == limit_reg);
                end
            end
            bsp_pkg::ST_DIV: begin
                if (div_done) begin
                    t_reg <= div_quot;
                    u_reg <= T_ONE - {1'b0, div_quot};
                end
            end
            bsp_pkg::ST_CMUL: prod_reg <= mul_p;
            bsp_pkg::ST_CWR: begin
                case (cop_reg)
                    bsp_pkg::COP_TT:   t2_reg    <= prod_reg[T_W +: T_W];
                    bsp_pkg::COP_T2T:  t3_reg    <= prod_reg[T_W +: T_W];
                    bsp_pkg::COP_UU:   u2_reg    <= prod_reg[T_W +: T_W + 1];
                    bsp_pkg::COP_U2U:  u3_reg    <= prod_reg[T_W +: T_W + 1];
                    bsp_pkg::COP_UT3:  tmp_reg   <= prod_reg[2*T_W-1:0];
                    bsp_pkg::COP_RED:  red_reg   <= prod_reg[2*T_W +: CW];
                    bsp_pkg::COP_U2T2: tmp_reg   <= prod_reg[2*T_W-1:0];
                    bsp_pkg::COP_GRN:  green_reg <= prod_reg[2*T_W +: CW];
                    bsp_pkg::COP_U3T:  tmp_reg   <= prod_reg[2*T_W-1:0];
                    bsp_pkg::COP_BLU:  blue_reg  <= prod_reg[2*T_W + 1 +: CW];
                    default: ;
                endcase
            end
            bsp_pkg::ST_DONE: begin
                if (out_free) begin
                    m_iterations_reg <= bsp_pkg::ITER_W'(count_reg);
                    m_inside_set_reg <= inside_reg;
                    m_red_reg        <= red_reg;
                    m_green_reg      <= green_reg;
                    m_blue_reg       <= blue_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_iterations = m_iterations_reg;
    assign m_inside_set = m_inside_set_reg;
    assign m_red        = m_red_reg;
    assign m_green      = m_green_reg;
    assign m_blue       = m_blue_reg;

    // The step count never runs past the limit while a point is in work.
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != bsp_pkg::ST_IDLE) |-> (count_reg <= limit_reg))
        else $error("step count exceeds limit");

    // A zero limit goes straight to the result.
    a_zero_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (limit_in == '0)) |=> (st_reg == bsp_pkg::ST_DONE))
        else $error("zero limit did not finish at once");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (st_reg == bsp_pkg::ST_DIV))
        else $error("divider finished outside its wait state");

    // Leaving the result state always presents a word.
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        ((st_reg == bsp_pkg::ST_DONE) && out_free) |=> m_valid_reg)
        else $error("result word not presented");

    // A point inside the set is black.
    a_inside_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_inside_set_reg) |->
            ((m_red_reg == '0) && (m_green_reg == '0) && (m_blue_reg == '0)))
        else $error("inside point has colour");

endmodule
